// ===== rtl/lbsa_pkg.sv =====
`default_nettype none

package lbsa_pkg;

  // Field widths
  localparam int AMP_BITS       = 24;
  localparam int BIN_INDEX_BITS = 16;
  localparam int TBL_IDX_BITS   = 6;
  localparam int BCOUNT_BITS    = 7;
  localparam int STEP_BITS      = 24;
  localparam int FREQ_BITS      = 39;
  localparam int SUM_BITS       = AMP_BITS + BIN_INDEX_BITS;
  localparam int SPAN_BITS      = BIN_INDEX_BITS + 1;
  localparam int PROD_BITS      = SPAN_BITS + STEP_BITS;

  localparam int MAX_BOUNDARIES_DEF = 64;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPECTRUM_SIZE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDARY_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_STEP_Q8    = 2'd2;

  localparam logic [BIN_INDEX_BITS-1:0] SPECTRUM_SIZE_RST  = 16'd1024;
  localparam logic [BCOUNT_BITS-1:0]    BOUNDARY_COUNT_RST = 7'd2;
  localparam logic [STEP_BITS-1:0]      BIN_STEP_RST       = 24'd6000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_BIN  = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [TBL_IDX_BITS-1:0]   table_index;
    logic [BIN_INDEX_BITS-1:0] boundary_value;
    logic [AMP_BITS-1:0]       amplitude;
    logic                      last_bin;
  } lbsa_in_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0] center_freq_q8;
    logic [AMP_BITS-1:0]  mean_amplitude;
    logic                 point_valid;
    logic                 last_point;
    logic                 size_error;
  } lbsa_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;  // latch bin beat
    logic tbl_wr;   // write boundary table entry
    logic rd_hi;    // read table[bp+1], else table[bp]
    logic cap_lo;
    logic cap_hi;
    logic skip;     // pass over current band
    logic add_bin;  // accumulate bin into current band
    logic finish;   // bump bin counter, clear on last bin
    logic emit;     // load output register
    logic point;    // result carries a finished band
  } lbsa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_mode;
    logic has_band;
    logic skip_band;
    logic in_band;
    logic band_end;
    logic div_done;
    logic out_free;
    logic last;
  } lbsa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/log_band_spectrum_averager_core.sv =====
// Table load beat: accepted and written to the table while idle, no result.
// Bin beat: straight to the result when no band is left, else the band's boundaries
// are read, plus one table RAM read for each empty or passed-over band, plus a serial
// divide when a band closes (2 quotient bits per cycle), plus any output wait.
// One bin is in flight at a time; a finished result waits in the output register.
// Async active-low reset clears config to defaults and all spectrum state;
// the boundary table is not cleared and must be loaded before use.
`default_nettype none

module log_band_spectrum_averager_core #(
  parameter int MAX_BOUNDARIES = lbsa_pkg::MAX_BOUNDARIES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire lbsa_pkg::lbsa_in_t                 in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output lbsa_pkg::lbsa_out_t                     out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [lbsa_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [lbsa_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  import lbsa_pkg::*;

  lbsa_cmd_t  cmd;
  lbsa_stat_t stat;

  lbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lbsa_datapath #(
    .MAX_BOUNDARIES (MAX_BOUNDARIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/lbsa_ram.sv =====
`default_nettype none

module lbsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lbsa_div.sv =====
`default_nettype none

// Restoring divider, two quotient bits per cycle.
module lbsa_div #(
  parameter int DW = 40,
  parameter int VW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic      [DW-1:0] quotient_o
);

  localparam int STEPS = (DW + 1) / 2;
  localparam int CNTW  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DW-1:0]   quo_q, quo_d;
  logic [VW:0]     rem_q, rem_d;
  logic [VW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  always_comb begin
    logic [VW:0]   r;
    logic [DW-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int j = 0; j < 2; j++) begin
      r = {r[VW-1:0], q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r    = r - {1'b0, dvs_q};
        q[0] = 1'b1;
      end
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/lbsa_datapath.sv =====
`default_nettype none

module lbsa_datapath #(
  parameter int MAX_BOUNDARIES = lbsa_pkg::MAX_BOUNDARIES_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lbsa_pkg::lbsa_in_t                    in_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output lbsa_pkg::lbsa_out_t                        out_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [lbsa_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire logic [lbsa_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  wire lbsa_pkg::lbsa_cmd_t                   cmd_i,
  output lbsa_pkg::lbsa_stat_t                       stat_o
);

  import lbsa_pkg::*;

  localparam int AW  = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
  localparam int BPW = $clog2(MAX_BOUNDARIES + 1);

  // Configuration
  logic [BIN_INDEX_BITS-1:0] size_q;
  logic [BCOUNT_BITS-1:0]    bcount_q;
  logic [STEP_BITS-1:0]      step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SPECTRUM_SIZE_RST;
      bcount_q <= BOUNDARY_COUNT_RST;
      step_q   <= BIN_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SPECTRUM_SIZE:  size_q   <= cfg_data_i[BIN_INDEX_BITS-1:0];
        REG_BOUNDARY_COUNT: bcount_q <= cfg_data_i[BCOUNT_BITS-1:0];
        REG_BIN_STEP_Q8:    step_q   <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Spectrum state
  logic [BPW-1:0]            bp_q;
  logic [SUM_BITS-1:0]       sum_q;
  logic [BIN_INDEX_BITS-1:0] bins_q;
  logic [BIN_INDEX_BITS-1:0] lower_q;
  logic [BIN_INDEX_BITS-1:0] counter_q;
  logic                      last_q;
  logic                      out_valid_q;

  // Payload registers
  logic [AMP_BITS-1:0]       amp_q;
  logic [BIN_INDEX_BITS-1:0] lo_q, hi_q;
  logic [SPAN_BITS-1:0]      span_q;
  logic [PROD_BITS-1:0]      prod_q;
  lbsa_out_t                 out_q;

  logic [BIN_INDEX_BITS-1:0] rdata;
  logic [BPW-1:0]            bp_inc;
  logic [BPW-1:0]            active_cnt;
  logic                      tbl_we;
  logic [BIN_INDEX_BITS-1:0] upper;
  logic                      band_end;
  logic [BIN_INDEX_BITS-1:0] lower_new;
  logic [SUM_BITS-1:0]       sum_new;
  logic [BIN_INDEX_BITS-1:0] bins_new;
  logic                      div_start;
  logic                      div_done;
  logic [SUM_BITS-1:0]       quotient;
  logic [FREQ_BITS-1:0]      freq;
  logic                      size_err;

  assign bp_inc = bp_q + 1'b1;

  always_comb begin
    if (32'(bcount_q) > 32'(MAX_BOUNDARIES)) begin
      active_cnt = BPW'(MAX_BOUNDARIES);
    end else begin
      active_cnt = BPW'(bcount_q);
    end
  end

  assign tbl_we = cmd_i.tbl_wr && (32'(in_i.table_index) < 32'(MAX_BOUNDARIES));

  lbsa_ram #(
    .WIDTH (BIN_INDEX_BITS),
    .DEPTH (MAX_BOUNDARIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(in_i.table_index)),
    .wdata_i (in_i.boundary_value),
    .raddr_i (cmd_i.rd_hi ? AW'(bp_inc) : AW'(bp_q)),
    .rdata_o (rdata)
  );

  // hi_q > counter_q whenever the band is not skipped, so upper never wraps there
  assign upper     = hi_q - 1'b1;
  assign band_end  = (counter_q == upper);
  assign lower_new = (bins_q == '0) ? lo_q : lower_q;
  assign sum_new   = sum_q + SUM_BITS'(amp_q);
  assign bins_new  = bins_q + 1'b1;
  assign div_start = cmd_i.add_bin && band_end;

  lbsa_div #(
    .DW (SUM_BITS),
    .VW (BIN_INDEX_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (bins_new),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q        <= '0;
      sum_q       <= '0;
      bins_q      <= '0;
      lower_q     <= '0;
      counter_q   <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        last_q <= in_i.last_bin;
      end
      if (cmd_i.skip) begin
        bp_q   <= bp_inc;
        sum_q  <= '0;
        bins_q <= '0;
      end else if (cmd_i.add_bin) begin
        lower_q <= lower_new;
        if (band_end) begin
          bp_q   <= bp_inc;
          sum_q  <= '0;
          bins_q <= '0;
        end else begin
          sum_q  <= sum_new;
          bins_q <= bins_new;
        end
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          counter_q <= '0;
          bp_q      <= '0;
          sum_q     <= '0;
          bins_q    <= '0;
          lower_q   <= '0;
        end else if (counter_q != '1) begin
          counter_q <= counter_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Saturate the Q8 centre frequency to 39 bits
  assign freq = prod_q[PROD_BITS-1] ? '1 : prod_q[FREQ_BITS:1];

  // bin count is counter+1, which also covers a saturated counter
  assign size_err = ({1'b0, counter_q} + {{BIN_INDEX_BITS{1'b0}}, 1'b1}) != {1'b0, size_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      amp_q <= in_i.amplitude;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata;
    end else if (cmd_i.skip) begin
      lo_q <= hi_q;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= rdata;
    end
    if (div_start) begin
      span_q <= {1'b0, lower_new} + {1'b0, upper};
    end
    prod_q <= PROD_BITS'(span_q) * PROD_BITS'(step_q);
    if (cmd_i.emit) begin
      out_q.center_freq_q8 <= cmd_i.point ? freq : '0;
      out_q.mean_amplitude <= cmd_i.point ? quotient[AMP_BITS-1:0] : '0;
      out_q.point_valid    <= cmd_i.point;
      out_q.last_point     <= last_q;
      out_q.size_error     <= last_q && size_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    stat_o           = '0;
    stat_o.in_mode   = in_i.mode;
    stat_o.has_band  = bp_inc < active_cnt;
    stat_o.skip_band = (hi_q <= lo_q) || (hi_q <= counter_q);
    stat_o.in_band   = counter_q >= lo_q;
    stat_o.band_end  = band_end;
    stat_o.div_done  = div_done;
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.last      = last_q;
  end

endmodule

`default_nettype wire

// ===== rtl/lbsa_ctrl.sv =====
`default_nettype none

module lbsa_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lbsa_pkg::lbsa_stat_t stat_i,
  output lbsa_pkg::lbsa_cmd_t       cmd_o
);

  import lbsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_LO,
    S_LOW,
    S_NEXT,
    S_HI,
    S_HIW,
    S_CHECK,
    S_DIV,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   need_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign need_out   = done_q || stat_i.last;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_mode == MODE_BIN) begin
            cmd_o.capture = 1'b1;
            done_d        = 1'b0;
            state_d       = S_TEST;
          end else begin
            cmd_o.tbl_wr = 1'b1;
          end
        end
      end
      S_TEST: begin
        state_d = stat_i.has_band ? S_LO : S_RESULT;
      end
      // table address defaults to bp, so table[bp] is being read here
      S_LO: begin
        state_d = S_LOW;
      end
      S_LOW: begin
        cmd_o.cap_lo = 1'b1;
        cmd_o.rd_hi  = 1'b1;
        state_d      = S_HIW;
      end
      // after a skip the old upper boundary already sits in lo
      S_NEXT: begin
        state_d = stat_i.has_band ? S_HI : S_RESULT;
      end
      S_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_HIW;
      end
      S_HIW: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.skip_band) begin
          cmd_o.skip = 1'b1;
          state_d    = S_NEXT;
        end else if (stat_i.in_band) begin
          cmd_o.add_bin = 1'b1;
          if (stat_i.band_end) begin
            done_d  = 1'b1;
            state_d = S_DIV;
          end else begin
            state_d = S_RESULT;
          end
        end else begin
          state_d = S_RESULT;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!need_out || stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.emit   = need_out;
          cmd_o.point  = done_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  a_emit_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result loaded while output beat still pending");

  a_skip_needs_band : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.skip |-> stat_i.has_band)
    else $error("band skipped past end of table");

  a_check_has_band : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> stat_i.has_band)
    else $error("band check without a valid band");

  a_div_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished while controller not waiting");

endmodule

`default_nettype wire

// ===== bench/tb_log_band_spectrum_averager_core.sv =====
`timescale 1ns / 100ps

module tb_log_band_spectrum_averager_core;
  import lbsa_pkg::*;

  localparam int MAX_EDGES        = MAX_BOUNDARIES_DEF;
  localparam int RESET_CYCLES     = 4;
  localparam int IDLE_PCT         = 34;
  // worst bin: the boundary reads, one more read per passed-over band, and the divide
  localparam int DRAIN_CYCLES     = 300;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT      = 5000;
  localparam int LONG_BINS        = 64;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_BEATS      = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [63:0] FREQ_ALL_ONES = (64'd1 << FREQ_BITS) - 64'd1;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  lbsa_in_t                 in_i        = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  lbsa_out_t                out_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  log_band_spectrum_averager_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic [BIN_INDEX_BITS-1:0] cfg_spectrum_size  = SPECTRUM_SIZE_RST;
  logic [BCOUNT_BITS-1:0]    cfg_boundary_count = BOUNDARY_COUNT_RST;
  logic [STEP_BITS-1:0]      cfg_bin_step       = BIN_STEP_RST;
  logic [BIN_INDEX_BITS-1:0] band_edges [MAX_EDGES];
  logic [BIN_INDEX_BITS-1:0] bin_count  = '0;
  int unsigned               band_idx   = 0;
  logic [63:0]               acc_sum    = '0;
  int unsigned               acc_bins   = 0;
  logic [BIN_INDEX_BITS-1:0] acc_lower  = '0;

  lbsa_out_t pending_points [$];
  int        mismatches = 0;

  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  function automatic void restart_spectrum();
    bin_count = '0;
    band_idx  = 0;
    acc_sum   = '0;
    acc_bins  = 0;
    acc_lower = '0;
  endfunction

  task automatic update_band_averages(input lbsa_in_t beat);
    logic [BIN_INDEX_BITS-1:0] k;
    logic [BIN_INDEX_BITS-1:0] upper;
    logic [63:0]               freq;
    int unsigned               active;
    lbsa_out_t                 point;
    bit                        closed;
    point  = '0;
    closed = 1'b0;
    if (beat.mode == MODE_LOAD) begin
      band_edges[beat.table_index] = beat.boundary_value;
    end else begin
      k      = bin_count;
      active = (cfg_boundary_count > MAX_EDGES) ? MAX_EDGES : cfg_boundary_count;
      // pass over empty bands and bands already behind this bin
      while (band_idx + 1 < active &&
             (band_edges[band_idx + 1] <= band_edges[band_idx] ||
              band_edges[band_idx + 1] <= k)) begin
        band_idx++;
        acc_sum  = '0;
        acc_bins = 0;
      end
      if (band_idx + 1 < active && k >= band_edges[band_idx]) begin
        upper = band_edges[band_idx + 1] - 1'b1;
        if (acc_bins == 0) acc_lower = band_edges[band_idx];
        acc_sum += 64'(beat.amplitude);
        acc_bins++;
        if (k == upper) begin
          freq = ((64'(acc_lower) + 64'(upper)) * 64'(cfg_bin_step)) >> 1;
          point.center_freq_q8 = (freq > FREQ_ALL_ONES) ? '1 : freq[FREQ_BITS-1:0];
          point.mean_amplitude = AMP_BITS'(acc_sum / 64'(acc_bins));
          point.point_valid    = 1'b1;
          closed   = 1'b1;
          band_idx++;
          acc_sum  = '0;
          acc_bins = 0;
        end
      end
      if (bin_count != '1) bin_count++;
      if (beat.last_bin) begin
        point.last_point = 1'b1;
        // counter saturates, so 17 bits hold the true count
        point.size_error = (({1'b0, k} + 17'd1) != {1'b0, cfg_spectrum_size});
        restart_spectrum();
      end
      if (closed || beat.last_bin) pending_points.push_back(point);
    end
  endtask

  task automatic send_beat(input lbsa_in_t beat);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    update_band_averages(beat);
  endtask

  task automatic send_load(input int unsigned idx, input logic [BIN_INDEX_BITS-1:0] val);
    lbsa_in_t b;
    b.mode           = MODE_LOAD;
    b.table_index    = idx[TBL_IDX_BITS-1:0];
    b.boundary_value = val;
    b.amplitude      = AMP_BITS'($urandom());
    b.last_bin       = 1'($urandom());
    send_beat(b);
  endtask

  task automatic send_bin(input logic [AMP_BITS-1:0] amp, input bit is_last);
    lbsa_in_t b;
    b.mode           = MODE_BIN;
    b.table_index    = TBL_IDX_BITS'($urandom());
    b.boundary_value = BIN_INDEX_BITS'($urandom());
    b.amplitude      = amp;
    b.last_bin       = is_last;
    send_beat(b);
  endtask

  function automatic logic [AMP_BITS-1:0] pick_amplitude();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return AMP_BITS'($urandom());
    endcase
  endfunction

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  // a bin that closes no band may still be in flight
  task automatic settle();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_SPECTRUM_SIZE:  cfg_spectrum_size  = data[BIN_INDEX_BITS-1:0];
      REG_BOUNDARY_COUNT: cfg_boundary_count = data[BCOUNT_BITS-1:0];
      REG_BIN_STEP_Q8:    cfg_bin_step       = data[STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic test_default_config();
    send_load(0, 16'd2);
    send_load(1, 16'd5);
    send_bin(24'h123456, 1'b0);
    send_bin('0, 1'b0);
    send_bin('1, 1'b0);
    send_bin('0, 1'b0);
    send_bin('1, 1'b0);
    send_bin(24'h000001, 1'b1);
  endtask

  // empty band, non-ascending entry, load beat mid-spectrum, bins past all bands,
  // and a last bin that also closes a band
  task automatic test_band_corner_cases();
    settle();
    write_reg(REG_SPECTRUM_SIZE, 24'd7);
    write_reg(REG_BOUNDARY_COUNT, 24'd5);
    write_reg(REG_BIN_STEP_Q8, 24'd256);
    send_load(0, 16'd1);
    send_load(1, 16'd1);
    send_load(2, 16'd3);
    send_load(3, 16'd2);
    send_load(4, 16'd6);
    for (int k = 0; k < 7; k++) begin
      if (k == 4) send_load(10, 16'hFFFF);
      send_bin(pick_amplitude(), k == 6);
    end
    for (int k = 0; k < 6; k++) send_bin(pick_amplitude(), k == 5);
  endtask

  task automatic test_band_count_below_two();
    settle();
    write_reg(REG_BOUNDARY_COUNT, 24'd0);
    for (int k = 0; k < 3; k++) send_bin(pick_amplitude(), k == 2);
    settle();
    write_reg(REG_BOUNDARY_COUNT, 24'd1);
    for (int k = 0; k < 2; k++) send_bin(pick_amplitude(), k == 1);
  endtask

  // one-bin bands with the sink held off: output register fills, input stalls
  task automatic test_output_backpressure();
    settle();
    write_reg(REG_SPECTRUM_SIZE, 24'd20);
    write_reg(REG_BOUNDARY_COUNT, 24'd20);
    write_reg(REG_BIN_STEP_Q8, CFG_DATA_BITS'($urandom()));
    for (int i = 0; i < 20; i++) send_load(i, BIN_INDEX_BITS'(i));
    src_idle_pct = 0;
    hold_requests++;
    for (int k = 0; k < 20; k++) send_bin(pick_amplitude(), k == 19);
    src_idle_pct = IDLE_PCT;
  endtask

  // spectrum far longer than the configured size at max step, with no idling on
  // either side; the count check must flag it
  task automatic test_overlong_spectrum();
    settle();
    write_reg(REG_SPECTRUM_SIZE, 24'd1);
    write_reg(REG_BOUNDARY_COUNT, 24'd2);
    write_reg(REG_BIN_STEP_Q8, '1);
    send_load(0, 16'd20);
    send_load(1, 16'd50);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (int k = 0; k < LONG_BINS; k++) send_bin(pick_amplitude(), k == LONG_BINS - 1);
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_spectra();
    logic [BIN_INDEX_BITS-1:0] new_edges [MAX_EDGES];
    logic [BCOUNT_BITS-1:0]    cnt_val;
    logic [BIN_INDEX_BITS-1:0] size_val;
    logic [STEP_BITS-1:0]      step_val;
    int unsigned               n, len, span_len, beats, top, prev, val;
    bit                        paused;
    settle();
    // every entry written once, so no read ever hits an unwritten one
    for (int i = 0; i < MAX_EDGES; i++) send_load(i, BIN_INDEX_BITS'($urandom()));
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       cnt_val = 7'd64;
        1:       cnt_val = 7'd127;
        2:       cnt_val = 7'd2;
        3:       cnt_val = 7'd1;
        4:       cnt_val = 7'd0;
        5:       cnt_val = BCOUNT_BITS'($urandom_range(3, 12));
        6:       cnt_val = BCOUNT_BITS'($urandom_range(13, 63));
        default: cnt_val = BCOUNT_BITS'($urandom_range(65, 126));
      endcase
      case (phase % 3)
        0:       step_val = '1;
        1:       step_val = '0;
        default: step_val = STEP_BITS'($urandom());
      endcase
      n    = (cnt_val > MAX_EDGES) ? MAX_EDGES : cnt_val;
      top  = 0;
      prev = 0;
      for (int i = 0; i < n; i++) begin
        if (i == 0) val = $urandom_range(0, 2);
        else if ($urandom_range(9) == 0) val = $urandom_range(0, prev);
        else val = prev + $urandom_range(0, 1);
        new_edges[i] = BIN_INDEX_BITS'(val);
        prev = val;
        if (val > top) top = val;
      end
      span_len = top + $urandom_range(1, 6);
      case (phase)
        1:       size_val = '1;
        4:       size_val = '0;
        default: size_val = BIN_INDEX_BITS'(span_len);
      endcase
      settle();
      write_reg(REG_SPECTRUM_SIZE, {8'($urandom()), size_val});
      write_reg(REG_BOUNDARY_COUNT, {17'($urandom()), cnt_val});
      write_reg(REG_BIN_STEP_Q8, step_val);
      if (phase == 0) write_reg(REG_UNMAPPED, CFG_DATA_BITS'($urandom()));
      for (int i = 0; i < n; i++) send_load(i, new_edges[i]);
      beats  = 0;
      paused = 1'b0;
      while (beats < PHASE_BEATS) begin
        // mostly well-formed spectra; some cut short or overlong
        len = ($urandom_range(4) == 0) ? $urandom_range(1, span_len + 3) : span_len;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(24) == 0) begin
            send_load($urandom_range(0, MAX_EDGES - 1),
                      BIN_INDEX_BITS'($urandom_range(0, span_len + 2)));
            beats++;
          end
          send_bin(pick_amplitude(), k == len - 1);
          beats++;
        end
        if (!paused) begin
          pause_until_drained();
          paused = 1'b1;
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = SINK_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_points
    lbsa_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        $error("result beat with nothing expected: %p", out_o);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (out_o.center_freq_q8 !== want.center_freq_q8) begin
          $error("center_freq_q8: expected %0d, actual %0d",
                 want.center_freq_q8, out_o.center_freq_q8);
          mismatches++;
        end
        if (out_o.mean_amplitude !== want.mean_amplitude) begin
          $error("mean_amplitude: expected %0d, actual %0d",
                 want.mean_amplitude, out_o.mean_amplitude);
          mismatches++;
        end
        if (out_o.point_valid !== want.point_valid) begin
          $error("point_valid: expected %0b, actual %0b", want.point_valid, out_o.point_valid);
          mismatches++;
        end
        if (out_o.last_point !== want.last_point) begin
          $error("last_point: expected %0b, actual %0b", want.last_point, out_o.last_point);
          mismatches++;
        end
        if (out_o.size_error !== want.size_error) begin
          $error("size_error: expected %0b, actual %0b", want.size_error, out_o.size_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    restart_spectrum();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_config();
    test_band_corner_cases();
    test_band_count_below_two();
    test_output_backpressure();
    test_overlong_spectrum();
    test_random_spectra();
    settle();
    if (pending_points.size() != 0) begin
      $error("%0d expected results never arrived", pending_points.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== log_band_spectrum_averager_core.f =====
rtl/lbsa_pkg.sv
rtl/lbsa_ram.sv
rtl/lbsa_div.sv
rtl/lbsa_datapath.sv
rtl/lbsa_ctrl.sv
rtl/log_band_spectrum_averager_core.sv
bench/tb_log_band_spectrum_averager_core.sv
